### hw/rtl/lsc_pkg.sv
// shared types for the lru slot cache with pinning
`default_nettype none

package lsc_pkg;

    localparam int unsigned SIZE_W  = 17;
    localparam int unsigned RID_W   = 16;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned MASK_W  = 16;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_TOUCH = 1'b1;

    localparam logic [SIZE_W-1:0] SLOT_BYTES_RST = 17'd4096;

    typedef struct packed {
        logic              func;
        logic [SIZE_W-1:0] request_size;
        logic [RID_W-1:0]  resource_id;
        logic [IDX_W-1:0]  slot_index;
        logic [MASK_W-1:0] locked_mask;
    } t_req;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] granted_slot;
        logic             evicted;
        logic [RID_W-1:0] evicted_id;
    } t_res;

    typedef struct packed {
        logic              act;
        logic              touch;
        logic [RID_W-1:0]  rid;
        logic [MASK_W-1:0] mask;
        logic [IDX_W-1:0]  tidx;
    } t_cmd;

endpackage

`default_nettype wire

### hw/rtl/lru_slot_cache_with_pinning.sv
// top level: request latch, row of recency cells, result register
`default_nettype none

// Slot cache with least-recently-used replacement that skips locked slots.
// A word is taken when i_start is high and o_busy is low; o_busy then goes
// high while the hit flag ripples once along the row of recency cells, and no
// new word is taken until o_busy falls. The result appears on o_res for
// exactly one cycle with o_done high and cannot be held off, so it must be
// captured then. Slot state is ready straight out of reset with no clearing
// pass; i_cfg_we writes the slot size and should only be used while the block
// is idle.

module lru_slot_cache_with_pinning
    import lsc_pkg::*;
#(
    parameter int unsigned SLOTS   = 16,
    parameter int unsigned ID_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire t_req              i_req,
    output logic                   o_done,
    output t_res                   o_res,
    input  wire logic              i_cfg_we,
    input  wire logic [SIZE_W-1:0] i_cfg_data
);

    localparam int unsigned SW = $clog2(SLOTS);

    logic [SIZE_W-1:0] r_slot_bytes;
    logic              r_busy;
    t_req              r_req;
    logic              r_done;
    t_res              r_res, n_res;

    t_cmd               cmd;
    logic               in_range;
    logic               fits;
    logic [SLOTS:0]     hit;
    logic [SLOTS-1:0]   sel;
    logic [SW-1:0]      slot_q  [SLOTS];
    logic               valid_q [SLOTS];
    logic [ID_BITS-1:0] owner_q [SLOTS];
    logic [SW-1:0]      prev_slot  [SLOTS];
    logic               prev_valid [SLOTS];
    logic [ID_BITS-1:0] prev_owner [SLOTS];
    logic [SW-1:0]      sel_slot;
    logic               sel_valid;
    logic [ID_BITS-1:0] sel_owner;

    always_comb begin
        in_range  = (32'(r_req.slot_index) < SLOTS);
        fits      = (r_req.request_size <= r_slot_bytes);
        cmd.act   = r_busy && ((r_req.func == FUNC_TOUCH) ? in_range : fits);
        cmd.touch = (r_req.func == FUNC_TOUCH);
        cmd.rid   = r_req.resource_id;
        cmd.mask  = r_req.locked_mask;
        cmd.tidx  = r_req.slot_index;
    end

    assign hit[SLOTS] = 1'b0;

    for (genvar p = 0; p < SLOTS; p++) begin : g_cell
        if (p == 0) begin : g_head
            assign prev_slot[p]  = sel_slot;
            assign prev_valid[p] = sel_valid;
            assign prev_owner[p] = sel_owner;
        end else begin : g_body
            assign prev_slot[p]  = slot_q[p-1];
            assign prev_valid[p] = valid_q[p-1];
            assign prev_owner[p] = owner_q[p-1];
        end

        lsc_cell #(
            .SW      (SW),
            .ID_BITS (ID_BITS),
            .POS     (p)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_hit        (hit[p+1]),
            .o_hit        (hit[p]),
            .o_sel        (sel[p]),
            .i_prev_slot  (prev_slot[p]),
            .i_prev_valid (prev_valid[p]),
            .i_prev_owner (prev_owner[p]),
            .o_slot       (slot_q[p]),
            .o_valid      (valid_q[p]),
            .o_owner      (owner_q[p])
        );
    end

    // selected cell is one-hot, so an or across the row reads it out
    always_comb begin
        sel_slot  = '0;
        sel_valid = 1'b0;
        sel_owner = '0;
        for (int p = 0; p < SLOTS; p++) begin
            sel_slot  = sel_slot  | (slot_q[p]  & {SW{sel[p]}});
            sel_valid = sel_valid | (valid_q[p] & sel[p]);
            sel_owner = sel_owner | (owner_q[p] & {ID_BITS{sel[p]}});
        end
    end

    always_comb begin
        n_res = '0;
        if (r_req.func == FUNC_TOUCH) begin
            if (in_range) begin
                n_res.ok           = 1'b1;
                n_res.granted_slot = r_req.slot_index;
            end
        end else if (hit[0]) begin
            n_res.ok           = 1'b1;
            n_res.granted_slot = IDX_W'(sel_slot);
            n_res.evicted      = sel_valid;
            n_res.evicted_id   = sel_valid ? RID_W'(sel_owner) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_bytes <= SLOT_BYTES_RST;
            r_busy       <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_slot_bytes <= i_cfg_data;
            end
            r_busy <= i_start && !r_busy;
            r_done <= r_busy;
        end
        if (i_start && !r_busy) begin
            r_req <= i_req;
        end
        if (r_busy) begin
            r_res <= n_res;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

### hw/rtl/lsc_cell.sv
// one recency position: slot number, valid bit and owner, shifting toward the tail on a touch
`default_nettype none

module lsc_cell
    import lsc_pkg::*;
#(
    parameter int unsigned SW      = 4,
    parameter int unsigned ID_BITS = 16,
    parameter int unsigned POS     = 0
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic               i_hit,
    output logic                    o_hit,
    output logic                    o_sel,
    input  wire logic [SW-1:0]      i_prev_slot,
    input  wire logic               i_prev_valid,
    input  wire logic [ID_BITS-1:0] i_prev_owner,
    output logic [SW-1:0]           o_slot,
    output logic                    o_valid,
    output logic [ID_BITS-1:0]      o_owner
);

    localparam int unsigned XW = SW + 5;

    logic [SW-1:0]      r_slot,  n_slot;
    logic               r_valid, n_valid;
    logic [ID_BITS-1:0] r_owner, n_owner;

    logic [XW-1:0] slot_x;
    logic          locked;
    logic          match;
    logic          cand;
    logic          here;

    always_comb begin
        slot_x = XW'(r_slot);
        locked = ((slot_x >> 4) == '0) && i_cmd.mask[slot_x[3:0]];
        match  = (slot_x == XW'(i_cmd.tidx));
        cand   = !r_valid || !locked;
        here   = i_cmd.act && (i_cmd.touch ? match : cand);
        o_hit  = i_hit || here;
        o_sel  = here && !i_hit;

        n_slot  = r_slot;
        n_valid = r_valid;
        n_owner = r_owner;
        if (i_cmd.act) begin
            if (i_cmd.touch) begin
                if (i_hit || here) begin
                    n_slot  = i_prev_slot;
                    n_valid = i_prev_valid;
                    n_owner = i_prev_owner;
                end
            end else if (o_sel) begin
                n_valid = 1'b1;
                n_owner = ID_BITS'(i_cmd.rid);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= SW'(POS);
            r_valid <= 1'b0;
        end else begin
            r_slot  <= n_slot;
            r_valid <= n_valid;
        end
        r_owner <= n_owner;
    end

    assign o_slot  = r_slot;
    assign o_valid = r_valid;
    assign o_owner = r_owner;

endmodule

`default_nettype wire

### hw/rtl/lsc_checker.sv
// port-level checks for the lru slot cache with pinning, bound to the top level
`default_nettype none

module lsc_checker
    import lsc_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_start,
    input wire logic o_busy,
    input wire logic o_done,
    input wire t_res o_res
);

    // accepted word goes busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("accepted word did not raise busy");

    // work ends in the result strobe, with busy low again
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> o_done && !o_busy)
        else $error("work cycle did not end in a result");

    // no result without a word in flight
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy))
        else $error("result strobe without a word");

    // failed word carries no slot or eviction
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_res.ok |->
            o_res.granted_slot == '0 && !o_res.evicted && o_res.evicted_id == '0)
        else $error("failed result has nonzero fields");

    // eviction only on a successful word
    a_evict_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.evicted |-> o_res.ok)
        else $error("eviction reported on a failed word");

endmodule

bind lru_slot_cache_with_pinning lsc_checker u_lsc_checker (.*);

`default_nettype wire
